// File: rtl/png_scanline_unfilter_unit_assert.svh
// Assertion macros for the PNG scanline unfilter unit.
// Included by the top level; no other dependencies.
`ifndef PNG_SCANLINE_UNFILTER_UNIT_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PSU_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("png unfilter assertion failed");
`define PSU_ASSERT_NXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("png unfilter assertion failed");
`else
`define PSU_ASSERT_IMP(label, ck, rn, ante, cons)
`define PSU_ASSERT_NXT(label, ck, rn, ante, cons)
`endif
`endif

// File: rtl/psu_pkg.sv
// Shared types and constants of the PNG scanline unfilter unit.
// No dependencies.
package psu_pkg;

    localparam int CFG_W     = 17;
    localparam int ROW_LIMIT = 16384;

    typedef enum logic [1:0] {
        CFG_ROW_BYTES       = 2'd0,
        CFG_BYTES_PER_PIXEL = 2'd1,
        CFG_ROW_COUNT       = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        FLT_NONE  = 3'd0,
        FLT_SUB   = 3'd1,
        FLT_UP    = 3'd2,
        FLT_AVG   = 3'd3,
        FLT_PAETH = 3'd4
    } filter_t;

    typedef enum logic [1:0] {
        FS_FILTER,
        FS_DATA,
        FS_HALT
    } front_state_t;

    typedef struct packed {
        logic [16:0] row_bytes;
        logic [3:0]  bytes_per_pixel;
        logic [14:0] row_count;
    } cfg_t;

    typedef struct packed {
        logic [7:0] raw_byte;
        filter_t    filter;
        logic       first_row;
        logic       row_start;
        logic       left_ok;
        logic       row_end;
        logic       image_end;
        logic       bad_filter;
    } op_ctrl_t;

endpackage

// File: rtl/psu_in_if.sv
// Input request channel of the PNG scanline unfilter unit.
// No dependencies.
interface psu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] raw_byte;
    logic       start_of_image;

    modport source (output valid, output raw_byte, output start_of_image, input ready);
    modport sink (input valid, input raw_byte, input start_of_image, output ready);
endinterface

// File: rtl/psu_out_if.sv
// Result request channel of the PNG scanline unfilter unit.
// No dependencies.
interface psu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;
    logic       row_end;
    logic       image_end;
    logic       bad_filter;

    modport source (output valid, output pixel_byte, output row_end, output image_end,
                    output bad_filter, input ready);
    modport sink (input valid, input pixel_byte, input row_end, input image_end,
                  input bad_filter, output ready);
endinterface

// File: rtl/psu_line_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psu_line_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/psu_op_queue.sv
// Short FIFO of classified requests between front and back of the unfilter unit.
// No dependencies.
module psu_op_queue #(
    parameter int W     = 32,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic [W-1:0] head_data,
    output logic         full,
    output logic         empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_data = entry_reg[rd_ptr_reg];
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);

endmodule

// File: rtl/psu_front.sv
// Front end of the unfilter unit: accepts stream bytes, tracks row and image position.
// Depends on psu_pkg and psu_in_if.
module psu_front #(
    parameter int AW = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  psu_pkg::cfg_t       cfg,
    psu_in_if.sink              in_ch,
    input  logic                q_full,
    output logic                push,
    output psu_pkg::op_ctrl_t   push_ctrl,
    output logic [AW-1:0]       push_pos
);

    psu_pkg::front_state_t state_reg, state_next, eff_state;
    psu_pkg::filter_t      filter_reg, filter_next, eff_filter;
    logic [AW-1:0]         pos_reg, pos_next, eff_pos;
    logic [13:0]           row_reg, row_next, eff_row;
    logic                  first_reg, first_next, eff_first;
    logic                  accept;
    logic                  row_done;
    logic                  image_done;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        eff_state  = in_ch.start_of_image ? psu_pkg::FS_FILTER : state_reg;
        eff_filter = in_ch.start_of_image ? psu_pkg::FLT_NONE : filter_reg;
        eff_pos    = in_ch.start_of_image ? '0 : pos_reg;
        eff_row    = in_ch.start_of_image ? '0 : row_reg;
        eff_first  = in_ch.start_of_image || first_reg;

        row_done   = (17'(eff_pos) + 17'd1) >= cfg.row_bytes;
        image_done = row_done && ((15'(eff_row) + 15'd1) >= cfg.row_count);

        state_next  = state_reg;
        filter_next = filter_reg;
        pos_next    = pos_reg;
        row_next    = row_reg;
        first_next  = first_reg;
        push        = 1'b0;

        push_pos             = eff_pos;
        push_ctrl.raw_byte   = in_ch.raw_byte;
        push_ctrl.filter     = eff_filter;
        push_ctrl.first_row  = eff_first;
        push_ctrl.row_start  = (eff_pos == '0);
        push_ctrl.left_ok    = 17'(eff_pos) >= 17'(cfg.bytes_per_pixel);
        push_ctrl.row_end    = row_done;
        push_ctrl.image_end  = image_done;
        push_ctrl.bad_filter = 1'b0;

        if (accept)
        begin
            state_next  = eff_state;
            filter_next = eff_filter;
            pos_next    = eff_pos;
            row_next    = eff_row;
            first_next  = eff_first;
            case (eff_state)
                psu_pkg::FS_FILTER:
                begin
                    if (in_ch.raw_byte > 8'(psu_pkg::FLT_PAETH))
                    begin
                        state_next           = psu_pkg::FS_HALT;
                        push                 = 1'b1;
                        push_ctrl.raw_byte   = '0;
                        push_ctrl.row_end    = 1'b0;
                        push_ctrl.image_end  = 1'b0;
                        push_ctrl.bad_filter = 1'b1;
                    end
                    else
                    begin
                        state_next  = psu_pkg::FS_DATA;
                        filter_next = psu_pkg::filter_t'(in_ch.raw_byte[2:0]);
                        pos_next    = '0;
                    end
                end
                psu_pkg::FS_DATA:
                begin
                    push = 1'b1;
                    if (image_done)
                    begin
                        state_next  = psu_pkg::FS_FILTER;
                        filter_next = psu_pkg::FLT_NONE;
                        pos_next    = '0;
                        row_next    = '0;
                        first_next  = 1'b1;
                    end
                    else if (row_done)
                    begin
                        state_next = psu_pkg::FS_FILTER;
                        pos_next   = '0;
                        row_next   = eff_row + 14'd1;
                        first_next = 1'b0;
                    end
                    else
                    begin
                        pos_next = eff_pos + AW'(1);
                    end
                end
                default:
                begin
                    state_next = psu_pkg::FS_HALT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= psu_pkg::FS_FILTER;
            filter_reg <= psu_pkg::FLT_NONE;
            pos_reg    <= '0;
            row_reg    <= '0;
            first_reg  <= 1'b1;
        end
        else
        begin
            state_reg  <= state_next;
            filter_reg <= filter_next;
            pos_reg    <= pos_next;
            row_reg    <= row_next;
            first_reg  <= first_next;
        end
    end

endmodule

// File: rtl/psu_back.sv
// Back end of the unfilter unit: line store lookup, prediction and result register.
// Depends on psu_pkg, psu_out_if and psu_line_ram.
module psu_back #(
    parameter int MAX_ROW_BYTES = 65536,
    parameter int MAX_BPP       = 8,
    parameter int AW            = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  psu_pkg::cfg_t      cfg,
    input  logic               q_empty,
    input  psu_pkg::op_ctrl_t  head_ctrl,
    input  logic [AW-1:0]      head_pos,
    output logic               pop,
    psu_out_if.source          out_ch
);

    localparam int BIW = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;

    logic              s1_valid_reg;
    psu_pkg::op_ctrl_t s1_ctrl_reg;
    logic [AW-1:0]     s1_pos_reg;
    logic              fwd_reg;
    logic [7:0]        fwd_val_reg;
    logic [7:0]        left_reg [MAX_BPP];
    logic [7:0]        left_next [MAX_BPP];
    logic [7:0]        ul_reg [MAX_BPP];
    logic [7:0]        ul_next [MAX_BPP];

    logic              out_valid_reg;
    logic [7:0]        out_pixel_reg;
    logic              out_row_end_reg;
    logic              out_image_end_reg;
    logic              out_bad_reg;

    logic              s1_fire;
    logic              ram_we;
    logic              fwd_hit;
    logic [7:0]        rd_data;
    logic [BIW-1:0]    bpp_idx;
    logic [7:0]        a_val, b_val, c_val;
    logic [7:0]        pred;
    logic [7:0]        val;
    logic [8:0]        avg_sum;
    logic signed [9:0] p_a, p_b, p_c;
    logic [9:0]        d_a, d_b, d_c;

    assign s1_fire = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign pop     = !q_empty && (!s1_valid_reg || s1_fire);
    assign ram_we  = s1_fire && !s1_ctrl_reg.bad_filter;
    assign fwd_hit = pop && ram_we && (head_pos == s1_pos_reg);
    assign bpp_idx = BIW'(cfg.bytes_per_pixel - 4'd1);

    psu_line_ram #(
        .WIDTH (8),
        .DEPTH (MAX_ROW_BYTES)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (s1_pos_reg),
        .wr_data (val),
        .rd_en   (pop),
        .rd_addr (head_pos),
        .rd_data (rd_data)
    );

    always_comb
    begin
        a_val = s1_ctrl_reg.left_ok ? left_reg[bpp_idx] : 8'd0;
        b_val = s1_ctrl_reg.first_row ? 8'd0 : (fwd_reg ? fwd_val_reg : rd_data);
        c_val = (s1_ctrl_reg.left_ok && !s1_ctrl_reg.first_row) ? ul_reg[bpp_idx] : 8'd0;

        avg_sum = {1'b0, a_val} + {1'b0, b_val};
        p_a = $signed({2'b00, b_val}) - $signed({2'b00, c_val});
        p_b = $signed({2'b00, a_val}) - $signed({2'b00, c_val});
        p_c = p_a + p_b;
        d_a = (p_a < 0) ? 10'(-p_a) : 10'(p_a);
        d_b = (p_b < 0) ? 10'(-p_b) : 10'(p_b);
        d_c = (p_c < 0) ? 10'(-p_c) : 10'(p_c);

        case (s1_ctrl_reg.filter)
            psu_pkg::FLT_NONE:  pred = 8'd0;
            psu_pkg::FLT_SUB:   pred = a_val;
            psu_pkg::FLT_UP:    pred = b_val;
            psu_pkg::FLT_AVG:   pred = avg_sum[8:1];
            psu_pkg::FLT_PAETH:
            begin
                if (d_a <= d_b && d_a <= d_c)
                begin
                    pred = a_val;
                end
                else if (d_b <= d_c)
                begin
                    pred = b_val;
                end
                else
                begin
                    pred = c_val;
                end
            end
            default:            pred = 8'd0;
        endcase

        val = s1_ctrl_reg.raw_byte + pred;

        for (int i = 0; i < MAX_BPP; i++)
        begin
            if (i == 0)
            begin
                left_next[i] = val;
                ul_next[i]   = b_val;
            end
            else
            begin
                left_next[i] = s1_ctrl_reg.row_start ? 8'd0 : left_reg[i - 1];
                ul_next[i]   = s1_ctrl_reg.row_start ? 8'd0 : ul_reg[i - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_ctrl_reg <= head_ctrl;
            s1_pos_reg  <= head_pos;
            fwd_reg     <= fwd_hit;
            fwd_val_reg <= val;
        end
        if (ram_we)
        begin
            for (int i = 0; i < MAX_BPP; i++)
            begin
                left_reg[i] <= left_next[i];
                ul_reg[i]   <= ul_next[i];
            end
        end
        if (s1_fire)
        begin
            out_pixel_reg     <= s1_ctrl_reg.bad_filter ? 8'd0 : val;
            out_row_end_reg   <= s1_ctrl_reg.row_end && !s1_ctrl_reg.bad_filter;
            out_image_end_reg <= s1_ctrl_reg.image_end && !s1_ctrl_reg.bad_filter;
            out_bad_reg       <= s1_ctrl_reg.bad_filter;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.pixel_byte = out_pixel_reg;
    assign out_ch.row_end    = out_row_end_reg;
    assign out_ch.image_end  = out_image_end_reg;
    assign out_ch.bad_filter = out_bad_reg;

endmodule

// File: rtl/png_scanline_unfilter_unit.sv
// Top level of the PNG scanline unfilter unit: configuration, front, queue and back.
// Depends on psu_pkg, psu_in_if, psu_out_if, psu_front, psu_op_queue, psu_back
// and png_scanline_unfilter_unit_assert.svh.
//
// Channel   Dir  Request carries
// in_ch     in   raw_byte, start_of_image
// out_ch    out  pixel_byte, row_end, image_end, bad_filter
// cfg_*     in   register index and data, write only
//
// One byte is accepted per cycle while the queue has room; one result leaves per cycle while
// out_ch is ready. A data byte passes the queue, the line store read and the result register.
// Valid filter bytes and dropped bytes yield no result; an invalid one yields bad_filter.
// The line store has one write and one read port, which sets the rate at one byte a cycle.
// Reset clears the position state; the line store needs no clearing pass.
// A stalled out_ch fills the two-entry queue and then holds in_ch.ready low.
module png_scanline_unfilter_unit #(
    parameter int MAX_ROW_BYTES = 65536,
    parameter int MAX_BPP       = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    psu_in_if.sink                    in_ch,
    psu_out_if.source                 out_ch,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [psu_pkg::CFG_W-1:0] cfg_data
);

    localparam int AW          = $clog2(MAX_ROW_BYTES);
    localparam int QUEUE_DEPTH = 2;
    localparam int OPW         = $bits(psu_pkg::op_ctrl_t) + AW;

    logic [16:0]       row_bytes_reg;
    logic [3:0]        bpp_reg;
    logic [14:0]       row_count_reg;
    psu_pkg::cfg_t     cfg;

    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    psu_pkg::op_ctrl_t push_ctrl;
    logic [AW-1:0]     push_pos;
    psu_pkg::op_ctrl_t head_ctrl;
    logic [AW-1:0]     head_pos;
    logic [OPW-1:0]    head_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg <= 17'd1;
            bpp_reg       <= 4'd4;
            row_count_reg <= 15'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                psu_pkg::CFG_ROW_BYTES:       row_bytes_reg <= cfg_data[16:0];
                psu_pkg::CFG_BYTES_PER_PIXEL: bpp_reg       <= cfg_data[3:0];
                psu_pkg::CFG_ROW_COUNT:       row_count_reg <= cfg_data[14:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (row_bytes_reg == 17'd0)
        begin
            cfg.row_bytes = 17'd1;
        end
        else if (row_bytes_reg > 17'(MAX_ROW_BYTES))
        begin
            cfg.row_bytes = 17'(MAX_ROW_BYTES);
        end
        else
        begin
            cfg.row_bytes = row_bytes_reg;
        end

        if (bpp_reg == 4'd0)
        begin
            cfg.bytes_per_pixel = 4'd1;
        end
        else if (bpp_reg > 4'(MAX_BPP))
        begin
            cfg.bytes_per_pixel = 4'(MAX_BPP);
        end
        else
        begin
            cfg.bytes_per_pixel = bpp_reg;
        end

        if (row_count_reg == 15'd0)
        begin
            cfg.row_count = 15'd1;
        end
        else if (row_count_reg > 15'(psu_pkg::ROW_LIMIT))
        begin
            cfg.row_count = 15'(psu_pkg::ROW_LIMIT);
        end
        else
        begin
            cfg.row_count = row_count_reg;
        end
    end

    psu_front #(
        .AW (AW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_ch     (in_ch),
        .q_full    (q_full),
        .push      (q_push),
        .push_ctrl (push_ctrl),
        .push_pos  (push_pos)
    );

    psu_op_queue #(
        .W     (OPW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({push_pos, push_ctrl}),
        .pop       (q_pop),
        .head_data (head_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign head_ctrl = psu_pkg::op_ctrl_t'(head_data[$bits(psu_pkg::op_ctrl_t)-1:0]);
    assign head_pos  = head_data[OPW-1:$bits(psu_pkg::op_ctrl_t)];

    psu_back #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .MAX_BPP       (MAX_BPP),
        .AW            (AW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_empty   (q_empty),
        .head_ctrl (head_ctrl),
        .head_pos  (head_pos),
        .pop       (q_pop),
        .out_ch    (out_ch)
    );

`include "png_scanline_unfilter_unit_assert.svh"

    `PSU_ASSERT_IMP(a_queue_no_overflow, clk, rst_n, q_push, !q_full)
    `PSU_ASSERT_IMP(a_queue_no_underflow, clk, rst_n, q_pop, !q_empty)
    `PSU_ASSERT_NXT(a_queue_fills, clk, rst_n, q_push && q_empty && !q_pop, !q_empty)
    `PSU_ASSERT_IMP(a_error_result_clean, clk, rst_n, out_ch.valid && out_ch.bad_filter,
        out_ch.pixel_byte == 8'd0 && !out_ch.row_end && !out_ch.image_end)
    `PSU_ASSERT_IMP(a_image_end_on_row_end, clk, rst_n, out_ch.valid && out_ch.image_end,
        out_ch.row_end)

endmodule

// File: test/png_scanline_unfilter_unit_tb.sv
// Self-checking testbench for png_scanline_unfilter_unit: a directed table, bulk runs at the
// register limits, then random images with random idling on both request channels.
// Depends on psu_pkg, psu_in_if, psu_out_if and the unit's RTL.
`timescale 1ns / 100ps

module png_scanline_unfilter_unit_tb;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       row_end;
        logic       image_end;
        logic       bad_filter;
    } pixel_result_t;

    typedef enum bit {
        STEP_BYTE,
        STEP_REG
    } step_kind_t;

    typedef struct packed {
        step_kind_t          kind;
        psu_pkg::cfg_index_t reg_index;
        logic [16:0]         reg_value;
        logic [7:0]          raw_byte;
        logic                start_mark;
        logic                typed;
        pixel_result_t       want;
    } directed_step_t;

    localparam int unsigned LINE_DEPTH = 65536;
    localparam int unsigned LEFT_DEPTH = 8;
    localparam pixel_result_t NO_PIXEL = '0;
    localparam pixel_result_t BAD_PIXEL = '{8'h00, 1'b0, 1'b0, 1'b1};
    localparam psu_pkg::cfg_index_t NO_REG = psu_pkg::CFG_ROW_BYTES;

    localparam directed_step_t DIRECTED_STEPS [29] = '{
        '{STEP_BYTE, NO_REG, 17'd0, 8'h00, 1'b1, 1'b0, NO_PIXEL},
        '{STEP_BYTE, NO_REG, 17'd0, 8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b0}},
        '{STEP_BYTE, NO_REG, 17'd0, 8'h04, 1'b0, 1'b0, NO_PIXEL},
        '{STEP_BYTE, NO_REG, 17'd0, 8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}},
        '{STEP_BYTE, NO_REG, 17'd0, 8'h05, 1'b0, 1'b1, BAD_PIXEL},
        '{STEP_BYTE, NO_REG, 17'd0, 8'h03, 1'b0, 1'b0, NO_PIXEL},
        '{STEP_BYTE, NO_REG, 17'd0, 8'h01, 1'b1, 1'b0, NO_PIXEL},
        '{STEP_BYTE, NO_REG, 17'd0, 8'h80, 1'b0, 1'b1, '{8'h80, 1'b1, 1'b1, 1'b0}},
        '{STEP_BYTE, NO_REG, 17'd0, 8'hFF, 1'b1, 1'b1, BAD_PIXEL},
        '{STEP_BYTE, NO_REG, 17'd0, 8'hFF, 1'b0, 1'b0, NO_PIXEL},
        '{STEP_REG, psu_pkg::CFG_ROW_BYTES, 17'd3, 8'h00, 1'b0, 1'b0, NO_PIXEL},
        '{STEP_REG, psu_pkg::CFG_BYTES_PER_PIXEL, 17'd1, 8'h00, 1'b0, 1'b0, NO_PIXEL},
        '{STEP_REG, psu_pkg::CFG_ROW_COUNT, 17'd4, 8'h00, 1'b0, 1'b0, NO_PIXEL},
        '{STEP_BYTE, NO_REG, 17'd0, 8'h01, 1'b1, 1'b0, NO_PIXEL},
        '{STEP_BYTE, NO_REG, 17'd0, 8'h10, 1'b0, 1'b0, NO_PIXEL},
        '{STEP_BYTE, NO_REG, 17'd0, 8'h20, 1'b0, 1'b0, NO_PIXEL},
        '{STEP_BYTE, NO_REG, 17'd0, 8'hF0, 1'b0, 1'b0, NO_PIXEL},
        '{STEP_BYTE, NO_REG, 17'd0, 8'h02, 1'b0, 1'b0, NO_PIXEL},
        '{STEP_BYTE, NO_REG, 17'd0, 8'h01, 1'b0, 1'b0, NO_PIXEL},
        '{STEP_BYTE, NO_REG, 17'd0, 8'h02, 1'b0, 1'b0, NO_PIXEL},
        '{STEP_BYTE, NO_REG, 17'd0, 8'h03, 1'b0, 1'b0, NO_PIXEL},
        '{STEP_BYTE, NO_REG, 17'd0, 8'h03, 1'b0, 1'b0, NO_PIXEL},
        '{STEP_BYTE, NO_REG, 17'd0, 8'hFF, 1'b0, 1'b0, NO_PIXEL},
        '{STEP_BYTE, NO_REG, 17'd0, 8'h00, 1'b0, 1'b0, NO_PIXEL},
        '{STEP_BYTE, NO_REG, 17'd0, 8'h7F, 1'b0, 1'b0, NO_PIXEL},
        '{STEP_BYTE, NO_REG, 17'd0, 8'h04, 1'b0, 1'b0, NO_PIXEL},
        '{STEP_BYTE, NO_REG, 17'd0, 8'h00, 1'b0, 1'b0, NO_PIXEL},
        '{STEP_BYTE, NO_REG, 17'd0, 8'h80, 1'b0, 1'b0, NO_PIXEL},
        '{STEP_BYTE, NO_REG, 17'd0, 8'hFF, 1'b0, 1'b0, NO_PIXEL}
    };

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    psu_pkg::cfg_index_t           cfg_index;
    logic [psu_pkg::CFG_W-1:0]     cfg_data;

    psu_in_if  byte_ch ();
    psu_out_if pixel_ch ();

    png_scanline_unfilter_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (byte_ch),
        .out_ch    (pixel_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    int unsigned row_bytes_reg = 1;
    int unsigned bpp_reg = 4;
    int unsigned row_count_reg = 1;

    bit [7:0]          line_store [LINE_DEPTH];
    bit [7:0]          left_win [LEFT_DEPTH];
    bit [7:0]          upleft_win [LEFT_DEPTH];
    int unsigned       byte_pos = 0;
    int unsigned       row_pos = 0;
    psu_pkg::filter_t  cur_filter = psu_pkg::FLT_NONE;
    bit                want_filter = 1'b1;
    bit                first_row = 1'b1;
    bit                halted = 1'b0;

    pixel_result_t pending_pixels [$];
    int unsigned   error_count = 0;
    int unsigned   working_items = 0;
    int unsigned   hold_cycles = 0;
    bit            need_mark = 1'b1;
    bit            bytes_idle = 1'b1;
    bit            results_idle = 1'b1;

    always #5 clk = ~clk;

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = psu_pkg::CFG_ROW_BYTES;
        cfg_data = '0;
        byte_ch.valid = 1'b0;
        byte_ch.raw_byte = '0;
        byte_ch.start_of_image = 1'b0;
        pixel_ch.ready = 1'b0;
    end

    initial begin
        #2ms;
        $display("tb: failure");
        $finish;
    end

    function automatic int unsigned clamp_range(input int unsigned v, input int unsigned lo,
                                                input int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void restart_image();
        left_win = '{default: '0};
        upleft_win = '{default: '0};
        byte_pos = 0;
        row_pos = 0;
        cur_filter = psu_pkg::FLT_NONE;
        want_filter = 1'b1;
        first_row = 1'b1;
        halted = 1'b0;
    endfunction

    // Returns 0 when the byte is dropped by an aborted image.
    function automatic bit unfilter_byte(input logic [7:0] raw, input bit mark,
                                         output bit has_pixel, output pixel_result_t res);
        int unsigned rb;
        int unsigned bpp;
        int unsigned rc;
        int unsigned pos;
        int a;
        int b;
        int c;
        int pred;
        int p;
        int da;
        int db;
        int dc;
        bit rend;
        bit iend;
        rb = clamp_range(row_bytes_reg, 1, LINE_DEPTH);
        bpp = clamp_range(bpp_reg, 1, LEFT_DEPTH);
        rc = clamp_range(row_count_reg, 1, psu_pkg::ROW_LIMIT);
        has_pixel = 1'b0;
        res = '0;
        if (mark) restart_image();
        if (halted) return 1'b0;
        if (want_filter) begin
            if (raw > 8'd4) begin
                halted = 1'b1;
                has_pixel = 1'b1;
                res.bad_filter = 1'b1;
                return 1'b1;
            end
            cur_filter = psu_pkg::filter_t'(raw[2:0]);
            want_filter = 1'b0;
            byte_pos = 0;
            left_win = '{default: '0};
            upleft_win = '{default: '0};
            return 1'b1;
        end
        pos = byte_pos & 32'hFFFF;
        b = first_row ? 0 : int'(line_store[pos]);
        a = (pos >= bpp) ? int'(left_win[bpp - 1]) : 0;
        c = (pos >= bpp && !first_row) ? int'(upleft_win[bpp - 1]) : 0;
        case (cur_filter)
            psu_pkg::FLT_SUB: pred = a;
            psu_pkg::FLT_UP: pred = b;
            psu_pkg::FLT_AVG: pred = (a + b) >> 1;
            psu_pkg::FLT_PAETH:
            begin
                p = a + b - c;
                da = (p > a) ? p - a : a - p;
                db = (p > b) ? p - b : b - p;
                dc = (p > c) ? p - c : c - p;
                if (da <= db && da <= dc) pred = a;
                else if (db <= dc) pred = b;
                else pred = c;
            end
            default: pred = 0;
        endcase
        res.pixel_byte = 8'(int'(raw) + pred);
        line_store[pos] = res.pixel_byte;
        for (int i = LEFT_DEPTH - 1; i > 0; i--)
        begin
            left_win[i] = left_win[i - 1];
            upleft_win[i] = upleft_win[i - 1];
        end
        left_win[0] = res.pixel_byte;
        upleft_win[0] = 8'(b);
        rend = (pos + 1 >= rb);
        iend = rend && (row_pos + 1 >= rc);
        if (iend) begin
            restart_image();
        end
        else if (rend) begin
            byte_pos = 0;
            row_pos = (row_pos + 1) & 32'h3FFF;
            want_filter = 1'b1;
            first_row = 1'b0;
        end
        else begin
            byte_pos = (pos + 1) & 32'hFFFF;
        end
        res.row_end = rend;
        res.image_end = iend;
        has_pixel = 1'b1;
        return 1'b1;
    endfunction

    task automatic write_reg(input psu_pkg::cfg_index_t idx, input int unsigned value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[psu_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            psu_pkg::CFG_ROW_BYTES: row_bytes_reg = value & 32'h1FFFF;
            psu_pkg::CFG_BYTES_PER_PIXEL: bpp_reg = value & 32'hF;
            psu_pkg::CFG_ROW_COUNT: row_count_reg = value & 32'h7FFF;
            default: ;
        endcase
        need_mark = 1'b1;
        @(posedge clk);
    endtask

    // A typed row replaces the predicted pixel with the one written in the table.
    task automatic send_byte(input logic [7:0] raw, input bit mark, input bit typed,
                             input pixel_result_t want);
        int gap;
        bit has_pixel;
        pixel_result_t res;
        gap = bytes_idle ? int'($urandom_range(15)) : 0;
        mark = mark | need_mark;
        need_mark = 1'b0;
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.raw_byte <= raw;
        byte_ch.start_of_image <= mark;
        do @(posedge clk); while (!byte_ch.ready);
        if (unfilter_byte(raw, mark, has_pixel, res)) working_items++;
        if (typed) pending_pixels.push_back(want);
        else if (has_pixel) pending_pixels.push_back(res);
    endtask

    task automatic send_image(input int unsigned width, input int unsigned rows,
                              input bit mark, input int unsigned cut);
        int unsigned sent;
        sent = 0;
        for (int unsigned r = 0; r < rows; r++)
        begin
            for (int unsigned k = 0; k <= width; k++)
            begin
                if (sent == cut) return;
                send_byte((k == 0) ? 8'($urandom_range(4)) : 8'($urandom),
                          mark && r == 0 && k == 0, 1'b0, NO_PIXEL);
                sent++;
            end
        end
    endtask

    task automatic wait_drain();
        byte_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_pixels.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk) begin
        pixel_result_t want;
        if (rst_n && pixel_ch.valid && pixel_ch.ready) begin
            if (pending_pixels.size() == 0) begin
                $error("pixel_byte: expected no request, got %0h", pixel_ch.pixel_byte);
                error_count++;
            end
            else begin
                want = pending_pixels.pop_front();
                compare_field("pixel_byte", want.pixel_byte, pixel_ch.pixel_byte);
                compare_field("row_end", 8'(want.row_end), 8'(pixel_ch.row_end));
                compare_field("image_end", 8'(want.image_end), 8'(pixel_ch.image_end));
                compare_field("bad_filter", 8'(want.bad_filter), 8'(pixel_ch.bad_filter));
            end
        end
    end

    initial begin
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = results_idle ? int'($urandom_range(15)) : 0;
            if (hold_cycles > 0) begin
                stall = int'(hold_cycles);
                hold_cycles = 0;
            end
            if (stall > 0) begin
                pixel_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pixel_ch.ready <= 1'b1;
            do @(posedge clk); while (!pixel_ch.valid);
        end
    end

    initial begin
        int unsigned random_goal;
        int unsigned target;
        int unsigned width;
        int unsigned rows;
        int unsigned pick;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_STEPS[i])
        begin
            if (DIRECTED_STEPS[i].kind == STEP_REG) begin
                wait_drain();
                write_reg(DIRECTED_STEPS[i].reg_index, 32'(DIRECTED_STEPS[i].reg_value));
            end
            else begin
                send_byte(DIRECTED_STEPS[i].raw_byte, DIRECTED_STEPS[i].start_mark,
                          DIRECTED_STEPS[i].typed, DIRECTED_STEPS[i].want);
            end
        end

        wait_drain();
        bytes_idle = 1'b0;
        results_idle = 1'b0;
        write_reg(psu_pkg::CFG_ROW_BYTES, 0);
        write_reg(psu_pkg::CFG_BYTES_PER_PIXEL, 0);
        write_reg(psu_pkg::CFG_ROW_COUNT, 32767);
        send_image(1, psu_pkg::ROW_LIMIT, 1'b1, 64);
        wait_drain();
        write_reg(psu_pkg::CFG_ROW_BYTES, 131071);
        write_reg(psu_pkg::CFG_BYTES_PER_PIXEL, 15);
        write_reg(psu_pkg::CFG_ROW_COUNT, 2);
        send_image(LINE_DEPTH, 2, 1'b1, 64);

        random_goal = working_items + 650;
        for (int ph = 0; working_items < random_goal; ph++)
        begin
            pick = $urandom_range(9);
            width = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(33, 64) : $urandom_range(1, 16);
            rows = $urandom_range(5);
            if (width <= 4 && $urandom_range(1) == 1) rows = $urandom_range(6, 24);
            wait_drain();
            bytes_idle = (ph == 1) ? 1'b0 : ($urandom_range(3) != 0);
            results_idle = (ph == 1) || ($urandom_range(3) != 0);
            write_reg(psu_pkg::CFG_ROW_BYTES, width);
            write_reg(psu_pkg::CFG_BYTES_PER_PIXEL, $urandom_range(15));
            write_reg(psu_pkg::CFG_ROW_COUNT, rows);
            if (ph == 1) hold_cycles = 400;
            width = clamp_range(width, 1, LINE_DEPTH);
            rows = clamp_range(rows, 1, psu_pkg::ROW_LIMIT);
            target = working_items + $urandom_range(60, 120);
            while (working_items < target)
            begin
                pick = $urandom_range(19);
                if (pick < 15) begin
                    send_image(width, rows, $urandom_range(3) != 0,
                               (pick == 0) ? $urandom_range(rows * (width + 1))
                                           : rows * (width + 1));
                end
                else if (pick < 17) begin
                    send_byte(8'($urandom_range(5, 255)), $urandom_range(1) == 1, 1'b0,
                              NO_PIXEL);
                    repeat ($urandom_range(4)) send_byte(8'($urandom), 1'b0, 1'b0, NO_PIXEL);
                end
                else begin
                    repeat ($urandom_range(1, 6))
                        send_byte(8'($urandom), $urandom_range(3) == 0, 1'b0, NO_PIXEL);
                end
            end
        end

        wait_drain();
        if (error_count == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule
